[rtl/vlcdc_pkg.sv]
// shared types, constants and codes for the dc coefficient extractor
package vlcdc_pkg;

   localparam int COEFFS_PER_BLOCK = 64;
   localparam int DC_BITS = 16;
   localparam int CIDX_W = (COEFFS_PER_BLOCK > 1) ? $clog2(COEFFS_PER_BLOCK) : 1;
   localparam int MAX_STARTS = 3;
   localparam int START_IDX_W = $clog2(MAX_STARTS);
   localparam int START_CNT_W = $clog2(MAX_STARTS + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [5:0] MB_COLUMNS_RST = 6'd8;
   localparam logic [5:0] MB_ROWS_RST = 6'd9;
   localparam logic [7:0] HEADER_SKIP_RST = 8'd40;
   localparam logic DIFF_MODE_RST = 1'b1;

   localparam logic [1:0] COMP_LUMA = 2'd0;
   localparam logic [1:0] COMP_CB = 2'd1;
   localparam logic [1:0] COMP_CR = 2'd2;

   localparam logic [2:0] BLOCK_CB = 3'd4;
   localparam logic [2:0] BLOCK_CR = 3'd5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MB_COLUMNS,
      CSR_MB_ROWS_TOTAL,
      CSR_HEADER_SKIP,
      CSR_DIFF_MODE
   } csr_index_type;

   typedef enum logic [2:0] {
      NODE_ROOT,
      NODE_0,
      NODE_1,
      NODE_10,
      NODE_11,
      NODE_111,
      NODE_1111,
      NODE_11111
   } prefix_node_type;

   typedef struct packed {
      logic [5:0] mb_columns;
      logic [5:0] mb_rows_total;
      logic [7:0] header_skip_bytes;
      logic       differential_mode;
   } cfg_type;

   typedef struct packed {
      logic              active;
      prefix_node_type   node;
      logic [3:0]        mag_size;
      logic [7:0]        mag_bits;
      logic [3:0]        mag_left;
      logic [CIDX_W-1:0] coeff_idx;
      logic [2:0]        block;
      logic [5:0]        col;
      logic [5:0]        row;
   } parse_state_type;

   typedef struct packed {
      logic [1:0]        component;
      logic signed [8:0] dc_difference;
   } start_type;

   typedef struct packed {
      logic                   clear;
      logic [START_CNT_W-1:0] num_starts;
      logic [5:0]             mb_col;
      logic [5:0]             mb_row;
      logic [1:0]             quadrant;
      logic                   frame_done;
      start_type [MAX_STARTS-1:0] starts;
   } queue_entry_type;

   typedef struct packed {
      logic [1:0]         component;
      logic [5:0]         mb_col;
      logic [5:0]         mb_row;
      logic [1:0]         quadrant;
      logic signed [8:0]  dc_difference;
      logic signed [15:0] dc_value;
      logic               frame_done;
   } result_type;

endpackage

[rtl/vlcdc_front.sv]
// front part: header skip, unrolled vlc bit walk and block position tracking
module vlcdc_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [7:0]                 data_byte,
   input  logic                       frame_start,
   input  vlcdc_pkg::cfg_type         cfg,
   input  logic                       queue_full,
   output logic                       push,
   output vlcdc_pkg::queue_entry_type entry
);
   import vlcdc_pkg::*;

   parse_state_type pst_ff, pst_in;
   logic [7:0]      header_left_ff, header_left_in;
   logic            accept;

   function automatic parse_state_type start_mag(parse_state_type s, logic [3:0] sz);
      parse_state_type ns;
      ns = s;
      ns.node = NODE_ROOT;
      ns.mag_size = sz;
      ns.mag_bits = '0;
      ns.mag_left = sz;
      return ns;
   endfunction

   function automatic void take_bit(input parse_state_type s, input logic b,
                                    output parse_state_type ns, output logic done,
                                    output logic signed [8:0] val);
      logic [8:0] mag;
      ns = s;
      done = 1'b0;
      val = '0;
      mag = '0;
      if (s.mag_left != 4'd0) begin
         ns.mag_bits = {s.mag_bits[6:0], b};
         ns.mag_left = s.mag_left - 4'd1;
         if (s.mag_left == 4'd1) begin
            done = 1'b1;
            mag = {1'b0, ns.mag_bits};
            if (mag < (9'd1 << (s.mag_size - 4'd1))) begin
               val = $signed(mag - (9'd1 << s.mag_size) + 9'd1);
            end else begin
               val = $signed(mag);
            end
         end
      end else begin
         case (s.node)
            NODE_ROOT: ns.node = b ? NODE_1 : NODE_0;
            NODE_0: ns = start_mag(s, b ? 4'd2 : 4'd1);
            NODE_1: ns.node = b ? NODE_11 : NODE_10;
            NODE_10: begin
               if (b) begin
                  ns = start_mag(s, 4'd3);
               end else begin
                  ns.node = NODE_ROOT;
                  done = 1'b1;
               end
            end
            NODE_11: begin
               if (b) ns.node = NODE_111;
               else ns = start_mag(s, 4'd4);
            end
            NODE_111: begin
               if (b) ns.node = NODE_1111;
               else ns = start_mag(s, 4'd5);
            end
            NODE_1111: begin
               if (b) ns.node = NODE_11111;
               else ns = start_mag(s, 4'd6);
            end
            default: ns = start_mag(s, b ? 4'd8 : 4'd7);
         endcase
      end
   endfunction

   always_comb begin
      parse_state_type         st;
      parse_state_type         nxt;
      logic                    walk;
      logic                    done;
      logic signed [8:0]       val;
      logic [1:0]              comp;
      logic [START_CNT_W-1:0]  nst;
      st = pst_ff;
      nxt = pst_ff;
      done = 1'b0;
      val = '0;
      comp = COMP_LUMA;
      header_left_in = header_left_ff;
      walk = 1'b0;
      entry = '0;
      nst = '0;
      if (frame_start) begin
         st = '0;
         st.active = 1'b1;
         header_left_in = cfg.header_skip_bytes;
         entry.clear = 1'b1;
      end
      if (st.active) begin
         if (header_left_in != 8'd0) header_left_in = header_left_in - 8'd1;
         else walk = 1'b1;
      end
      for (int i = 7; i >= 0; i--) begin
         if (walk && st.active) begin
            take_bit(st, data_byte[i], nxt, done, val);
            st = nxt;
            if (done) begin
               if (st.coeff_idx == '0) begin
                  if (st.block < BLOCK_CB) comp = COMP_LUMA;
                  else if (st.block == BLOCK_CB) comp = COMP_CB;
                  else comp = COMP_CR;
                  if (nst == '0) begin
                     entry.mb_col = st.col;
                     entry.mb_row = st.row;
                     entry.quadrant = (st.block < BLOCK_CB) ? st.block[1:0] : 2'd0;
                     entry.frame_done = (comp == COMP_CR) &&
                                        (st.col + 6'd1 == cfg.mb_columns) &&
                                        (st.row + 6'd1 == cfg.mb_rows_total);
                  end
                  entry.starts[nst[START_IDX_W-1:0]].component = comp;
                  entry.starts[nst[START_IDX_W-1:0]].dc_difference = val;
                  nst = nst + 1'b1;
               end
               if (st.coeff_idx == CIDX_W'(COEFFS_PER_BLOCK - 1)) begin
                  st.coeff_idx = '0;
                  if (st.block == BLOCK_CR) begin
                     st.block = '0;
                     if (st.col + 6'd1 == cfg.mb_columns) begin
                        st.col = '0;
                        if (st.row + 6'd1 == cfg.mb_rows_total) st.active = 1'b0;
                        st.row = st.row + 6'd1;
                     end else begin
                        st.col = st.col + 6'd1;
                     end
                  end else begin
                     st.block = st.block + 3'd1;
                  end
               end else begin
                  st.coeff_idx = st.coeff_idx + 1'b1;
               end
            end
         end
      end
      entry.num_starts = nst;
      pst_in = st;
   end

   assign in_ready = !queue_full;
   assign accept = in_valid && in_ready;
   assign push = accept && (entry.clear || entry.num_starts != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pst_ff <= '0;
         header_left_ff <= '0;
      end else if (accept) begin
         pst_ff <= pst_in;
         header_left_ff <= header_left_in;
      end
   end

   a_start_activates: assert property (@(posedge clock) disable iff (reset)
      accept && frame_start |=> pst_ff.active)
      else $error("frame start did not activate parser");

   a_header_only_active: assert property (@(posedge clock) disable iff (reset)
      header_left_ff != 8'd0 |-> pst_ff.active)
      else $error("header bytes pending while no frame active");

endmodule

[rtl/vlcdc_queue.sv]
// short request queue between front and back parts
module vlcdc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  vlcdc_pkg::queue_entry_type wdata,
   input  logic                       pop,
   output vlcdc_pkg::queue_entry_type rdata,
   output logic                       empty,
   output logic                       full
);
   import vlcdc_pkg::*;

   queue_entry_type   mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign empty = count_ff == '0;
   assign full = count_ff == (QPTR_W + 1)'(QUEUE_DEPTH);
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= wdata;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue pop while empty");

endmodule

[rtl/vlcdc_back.sv]
// back part: per-component predictors with saturation and the result register
module vlcdc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  vlcdc_pkg::queue_entry_type head,
   input  logic                       head_valid,
   output logic                       pop,
   input  logic                       differential_mode,
   output logic                       out_valid,
   input  logic                       out_ready,
   output vlcdc_pkg::result_type      result
);
   import vlcdc_pkg::*;

   logic signed [DC_BITS-1:0] pred_ff [3];
   logic signed [DC_BITS-1:0] pred_in [3];
   logic signed [DC_BITS-1:0] base [3];
   logic [START_IDX_W-1:0]    ptr_ff, ptr_in;
   logic                      out_valid_ff, out_valid_in;
   result_type                out_ff, out_in;
   start_type                 slot;
   logic signed [8:0]         diff;
   logic signed [DC_BITS:0]   sum;
   logic signed [DC_BITS-1:0] sat;
   logic                      first, has_start, reporting, out_free, go, last_slot;

   always_comb begin
      first = ptr_ff == '0;
      has_start = head.num_starts != '0;
      reporting = first && has_start;
      out_free = !out_valid_ff || out_ready;
      go = head_valid && (!reporting || out_free);
      slot = head.starts[ptr_ff];
      diff = $signed(slot.dc_difference);
      last_slot = !has_start || (START_CNT_W'(ptr_ff) == head.num_starts - 1'b1);
      for (int c = 0; c < 3; c++) begin
         base[c] = (first && head.clear) ? '0 : pred_ff[c];
      end
      sum = (DC_BITS + 1)'(base[slot.component]) + (DC_BITS + 1)'(diff);
      if (sum[DC_BITS] != sum[DC_BITS-1]) begin
         sat = sum[DC_BITS] ? {1'b1, {(DC_BITS - 1){1'b0}}} : {1'b0, {(DC_BITS - 1){1'b1}}};
      end else begin
         sat = sum[DC_BITS-1:0];
      end
   end

   always_comb begin
      pred_in = pred_ff;
      ptr_in = ptr_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_in = out_ff;
      if (go) begin
         pred_in = base;
         if (has_start) pred_in[slot.component] = sat;
         ptr_in = last_slot ? '0 : ptr_ff + 1'b1;
         if (reporting) begin
            out_valid_in = 1'b1;
            out_in.component = slot.component;
            out_in.mb_col = head.mb_col;
            out_in.mb_row = head.mb_row;
            out_in.quadrant = head.quadrant;
            out_in.dc_difference = diff;
            out_in.dc_value = differential_mode ? 16'(sat) : 16'(diff);
            out_in.frame_done = head.frame_done;
         end
      end
   end

   assign pop = go && last_slot;
   assign out_valid = out_valid_ff;
   assign result = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 3; c++) pred_ff[c] <= '0;
         ptr_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pred_ff <= pred_in;
         ptr_ff <= ptr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      head_valid && ptr_ff != '0 |-> START_CNT_W'(ptr_ff) < head.num_starts)
      else $error("start pointer beyond entry");

   a_report_lands: assert property (@(posedge clock) disable iff (reset)
      go && reporting |=> out_valid_ff)
      else $error("reported block start lost");

endmodule

[rtl/vlc_dc_coefficient_extractor_unit.sv]
// top level of the vlc dc coefficient extractor
//
// req channel: one frame byte per request, tdata = data_byte, tuser = frame_start.
// a request with frame_start clears the parser, counters and predictors and
// reloads the header skip count. bits are read msb first.
// rsp channel: one result per byte with block starts, for the first start in it,
// tdata = position and dc values, tuser = component, tlast = last block of frame.
// csr port: csr_we writes register csr_index with csr_wdata in that same edge;
// write only while no request is in flight.
// a request's entry enters the queue at the accepting edge; the result register
// loads from it once it is at the queue head and the result register is free.
// throughput: one request per cycle while the queue is not full, set by the unrolled
// 8-bit walk in the front part; a byte that ends several block starts holds the back
// part while it applies each extra start in turn (only possible with very short blocks).
// a four-entry queue decouples front and back; when rsp_tready stays low the
// result register holds, the queue fills and req_tready drops.
// reset: registers return to 8 columns, 9 rows, 40 header bytes, differential
// mode; parser idle, queue and result register empty. no clearing pass.
module vlc_dc_coefficient_extractor_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // data_byte
   input  logic                               req_tuser,  // frame_start
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [39:0] rsp_tdata,  // mb_col, mb_row, quadrant, dc_difference, dc_value
   output logic [1:0]                         rsp_tuser,  // component
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [vlcdc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [vlcdc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import vlcdc_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   queue_entry_type push_entry, head;
   logic            push, pop, q_empty, q_full;
   result_type      result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MB_COLUMNS: cfg_in.mb_columns = csr_wdata[5:0];
            CSR_MB_ROWS_TOTAL: cfg_in.mb_rows_total = csr_wdata[5:0];
            CSR_HEADER_SKIP: cfg_in.header_skip_bytes = csr_wdata[7:0];
            CSR_DIFF_MODE: cfg_in.differential_mode = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mb_columns <= MB_COLUMNS_RST;
         cfg_ff.mb_rows_total <= MB_ROWS_RST;
         cfg_ff.header_skip_bytes <= HEADER_SKIP_RST;
         cfg_ff.differential_mode <= DIFF_MODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vlcdc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .data_byte   (req_tdata),
      .frame_start (req_tuser),
      .cfg         (cfg_ff),
      .queue_full  (q_full),
      .push        (push),
      .entry       (push_entry)
   );

   vlcdc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (push_entry),
      .pop   (pop),
      .rdata (head),
      .empty (q_empty),
      .full  (q_full)
   );

   vlcdc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .head_valid        (!q_empty),
      .pop               (pop),
      .differential_mode (cfg_ff.differential_mode),
      .out_valid         (rsp_tvalid),
      .out_ready         (rsp_tready),
      .result            (result)
   );

   assign rsp_tdata = {1'b0, result.dc_value, result.dc_difference, result.quadrant,
                       result.mb_row, result.mb_col};
   assign rsp_tuser = result.component;
   assign rsp_tlast = result.frame_done;

endmodule
